// File: src/grid_path_shortcut_defines.svh
// Assertion macros shared by the grid path shortcut RTL.
`ifndef GRID_PATH_SHORTCUT_DEFINES_SVH
`define GRID_PATH_SHORTCUT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("grid_path_shortcut: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("grid_path_shortcut: next-cycle check failed");

`endif

// File: src/gps_pkg.sv
// Package with types and constants of the grid path shortcut.
package gps_pkg;

    localparam int COORD_W     = 8;
    localparam int MAX_SIDE    = 1 << COORD_W;
    localparam int MAP_AW      = 2 * COORD_W;
    localparam int MAP_DEPTH   = 1 << MAP_AW;
    localparam int DIM_W       = COORD_W + 1;
    localparam int MAX_CORNERS = 64;
    localparam int CORNER_AW   = $clog2(MAX_CORNERS);
    localparam int COUNT_W     = CORNER_AW + 1;
    localparam int POINT_W     = 2 * COORD_W;
    localparam int ERR_W       = COORD_W + 4;

    localparam logic signed [7:0] BLOCKED_CODE = 8'sd100;
    localparam logic [DIM_W-1:0]  DIM_RESET    = DIM_W'(MAX_SIDE);

    localparam logic OP_GRID = 1'b0;
    localparam logic OP_PATH = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] RAW_ZERO = 2'd0;
    localparam logic [1:0] RAW_ONE  = 2'd1;
    localparam logic [1:0] RAW_TWO  = 2'd2;
    localparam logic [1:0] RAW_MANY = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [7:0]        cell_x;
        logic [7:0]        cell_y;
        logic signed [7:0] occupancy;
        logic              path_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic       out_last;
        logic       overflow;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHORT_FIRST,
        ST_SHORT_SECOND,
        ST_STORE_END,
        ST_RD_I,
        ST_LOAD_I,
        ST_CHECK_J,
        ST_RD_J,
        ST_LOAD_J,
        ST_BOUNDS,
        ST_WALK_A,
        ST_WALK_B,
        ST_EMIT_I,
        ST_NEXT_I,
        ST_EMIT_END
    } state_t;

    typedef enum logic [1:0] {
        SRC_FIRST,
        SRC_SECOND,
        SRC_CORNER,
        SRC_END
    } emit_src_t;

    typedef struct packed {
        logic      accept;
        logic      store_end;
        logic      rd_sel_i;
        logic      load_i;
        logic      load_j;
        logic      walk_step;
        logic      dec_j;
        logic      take_far_j;
        logic      next_i;
        logic      emit;
        emit_src_t emit_src;
        logic      emit_last;
        logic      clear_path;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       in_op;
        logic       in_end;
        logic [1:0] raw;
        logic       out_free;
        logic       j_more;
        logic       bounds_ok;
        logic       blocked;
        logic       at_end;
        logic       more_i;
    } dp_status_t;

endpackage

// File: src/gps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/gps_ctrl.sv
// Controller state machine of the grid path shortcut.
module gps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gps_pkg::dp_status_t sts,
    output gps_pkg::ctrl_cmd_t  cmd
);

    gps_pkg::state_t state_reg;
    gps_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gps_pkg::ST_IDLE: begin
                if (s_valid && sts.in_op == gps_pkg::OP_PATH && sts.in_end) begin
                    if (sts.raw == gps_pkg::RAW_ZERO) begin
                        state_next = gps_pkg::ST_EMIT_END;
                    end else if (sts.raw == gps_pkg::RAW_MANY) begin
                        state_next = gps_pkg::ST_STORE_END;
                    end else begin
                        state_next = gps_pkg::ST_SHORT_FIRST;
                    end
                end
            end
            gps_pkg::ST_SHORT_FIRST: begin
                if (sts.out_free) begin
                    state_next = (sts.raw == gps_pkg::RAW_TWO) ?
                        gps_pkg::ST_SHORT_SECOND : gps_pkg::ST_EMIT_END;
                end
            end
            gps_pkg::ST_SHORT_SECOND: begin
                if (sts.out_free) begin
                    state_next = gps_pkg::ST_EMIT_END;
                end
            end
            gps_pkg::ST_STORE_END: state_next = gps_pkg::ST_RD_I;
            gps_pkg::ST_RD_I:      state_next = gps_pkg::ST_LOAD_I;
            gps_pkg::ST_LOAD_I:    state_next = gps_pkg::ST_CHECK_J;
            gps_pkg::ST_CHECK_J: begin
                state_next = sts.j_more ? gps_pkg::ST_RD_J : gps_pkg::ST_EMIT_I;
            end
            gps_pkg::ST_RD_J:   state_next = gps_pkg::ST_LOAD_J;
            gps_pkg::ST_LOAD_J: state_next = gps_pkg::ST_BOUNDS;
            gps_pkg::ST_BOUNDS: begin
                state_next = sts.bounds_ok ? gps_pkg::ST_WALK_A : gps_pkg::ST_CHECK_J;
            end
            gps_pkg::ST_WALK_A: state_next = gps_pkg::ST_WALK_B;
            gps_pkg::ST_WALK_B: begin
                if (sts.blocked) begin
                    state_next = gps_pkg::ST_CHECK_J;
                end else if (sts.at_end) begin
                    state_next = gps_pkg::ST_EMIT_I;
                end else begin
                    state_next = gps_pkg::ST_WALK_A;
                end
            end
            gps_pkg::ST_EMIT_I: begin
                if (sts.out_free) begin
                    state_next = gps_pkg::ST_NEXT_I;
                end
            end
            gps_pkg::ST_NEXT_I: begin
                state_next = sts.more_i ? gps_pkg::ST_RD_I : gps_pkg::ST_EMIT_END;
            end
            gps_pkg::ST_EMIT_END: begin
                if (sts.out_free) begin
                    state_next = gps_pkg::ST_IDLE;
                end
            end
            default: state_next = gps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.emit_src   = gps_pkg::SRC_END;
        case (state_reg)
            gps_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            gps_pkg::ST_SHORT_FIRST: begin
                cmd.emit     = sts.out_free;
                cmd.emit_src = gps_pkg::SRC_FIRST;
            end
            gps_pkg::ST_SHORT_SECOND: begin
                cmd.emit     = sts.out_free;
                cmd.emit_src = gps_pkg::SRC_SECOND;
            end
            gps_pkg::ST_STORE_END: cmd.store_end = 1'b1;
            gps_pkg::ST_RD_I:      cmd.rd_sel_i  = 1'b1;
            gps_pkg::ST_LOAD_I:    cmd.load_i    = 1'b1;
            gps_pkg::ST_CHECK_J:   cmd.rd_sel_i  = 1'b0;
            gps_pkg::ST_RD_J:      cmd.rd_sel_i  = 1'b0;
            gps_pkg::ST_LOAD_J:    cmd.load_j    = 1'b1;
            gps_pkg::ST_BOUNDS:    cmd.dec_j     = !sts.bounds_ok;
            gps_pkg::ST_WALK_A:    cmd.rd_sel_i  = 1'b0;
            gps_pkg::ST_WALK_B: begin
                cmd.dec_j      = sts.blocked;
                cmd.take_far_j = !sts.blocked && sts.at_end;
                cmd.walk_step  = !sts.blocked && !sts.at_end;
            end
            gps_pkg::ST_EMIT_I: begin
                cmd.emit     = sts.out_free;
                cmd.emit_src = gps_pkg::SRC_CORNER;
                cmd.next_i   = sts.out_free;
            end
            gps_pkg::ST_NEXT_I: cmd.rd_sel_i = 1'b0;
            gps_pkg::ST_EMIT_END: begin
                cmd.emit       = sts.out_free;
                cmd.emit_src   = gps_pkg::SRC_END;
                cmd.emit_last  = 1'b1;
                cmd.clear_path = sts.out_free;
            end
            default: s_ready = 1'b0;
        endcase
    end

endmodule

// File: src/gps_dp.sv
// Datapath of the grid path shortcut: grid map, corner store, line walker, result register.
module gps_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gps_pkg::in_item_t      s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output gps_pkg::out_item_t     m_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [gps_pkg::DIM_W-1:0] cfg_data,
    input  gps_pkg::ctrl_cmd_t     cmd,
    output gps_pkg::dp_status_t    sts
);

    localparam int CW = gps_pkg::COORD_W;
    localparam int AW = gps_pkg::CORNER_AW;
    localparam int NW = gps_pkg::COUNT_W;
    localparam int EW = gps_pkg::ERR_W;

    logic [gps_pkg::DIM_W-1:0] map_width_reg, map_height_reg;
    logic [NW-1:0]             cc_reg, n_reg;
    logic [1:0]                raw_reg;
    gps_pkg::point_t           pending_reg, second_reg, first_reg, last_reg, end_reg;
    gps_pkg::point_t           pa_reg, pb_reg;
    logic                      ovf_reg;
    logic [AW-1:0]             i_reg, j_reg, far_reg;
    logic [CW-1:0]             wx_reg, wy_reg;
    logic signed [EW-1:0]      err_reg, dx_reg, dy_reg;
    logic                      sx_reg, sy_reg;
    logic                      m_valid_reg;
    gps_pkg::out_item_t        m_data_reg;

    gps_pkg::point_t           p_in, c_rdata, b_pt, src_pt;
    logic                      map_we, map_rdata, path_acc, cross_case, cross_nz, room;
    logic                      c_we;
    logic [AW-1:0]             c_waddr, c_raddr;
    gps_pkg::point_t           c_wdata;
    logic signed [CW:0]        vx1, vy1, vx2, vy2;
    logic signed [2*CW+1:0]    m1, m2;
    logic [CW-1:0]             ax, ay;
    logic signed [EW:0]        e2;
    logic                      step_x, step_y;
    logic signed [EW-1:0]      err_step;

    assign p_in     = '{y: s_data.cell_y, x: s_data.cell_x};
    assign map_we   = cmd.accept && s_data.operation == gps_pkg::OP_GRID;
    assign path_acc = cmd.accept && s_data.operation == gps_pkg::OP_PATH;

    gps_ram #(.WIDTH(1), .DEPTH(gps_pkg::MAP_DEPTH)) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr ({s_data.cell_y, s_data.cell_x}),
        .wdata (s_data.occupancy == gps_pkg::BLOCKED_CODE),
        .raddr ({wy_reg, wx_reg}),
        .rdata (map_rdata)
    );

    gps_ram #(.WIDTH(gps_pkg::POINT_W), .DEPTH(gps_pkg::MAX_CORNERS)) u_corner (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // Turn test of last kept corner, pending point and new point.
    assign vx1 = $signed({1'b0, pending_reg.x}) - $signed({1'b0, last_reg.x});
    assign vy1 = $signed({1'b0, pending_reg.y}) - $signed({1'b0, last_reg.y});
    assign vx2 = $signed({1'b0, p_in.x}) - $signed({1'b0, pending_reg.x});
    assign vy2 = $signed({1'b0, p_in.y}) - $signed({1'b0, pending_reg.y});
    assign m1  = vx1 * vy2;
    assign m2  = vy1 * vx2;
    assign cross_nz   = (m1 != m2);
    assign cross_case = (raw_reg == gps_pkg::RAW_TWO && !s_data.path_end) ||
                        (raw_reg == gps_pkg::RAW_MANY);
    assign room       = cc_reg < NW'(gps_pkg::MAX_CORNERS - 1);

    always_comb begin
        c_we    = 1'b0;
        c_waddr = cc_reg[AW-1:0];
        c_wdata = pending_reg;
        if (cmd.store_end) begin
            c_we    = 1'b1;
            c_wdata = end_reg;
        end else if (path_acc && raw_reg == gps_pkg::RAW_ZERO && !s_data.path_end) begin
            c_we    = 1'b1;
            c_waddr = '0;
            c_wdata = p_in;
        end else if (path_acc && cross_case && cross_nz && room) begin
            c_we    = 1'b1;
        end
    end

    assign c_raddr = cmd.rd_sel_i ? i_reg : j_reg;
    assign b_pt    = c_rdata;
    assign ax = (b_pt.x > pa_reg.x) ? b_pt.x - pa_reg.x : pa_reg.x - b_pt.x;
    assign ay = (b_pt.y > pa_reg.y) ? b_pt.y - pa_reg.y : pa_reg.y - b_pt.y;

    assign e2       = {err_reg, 1'b0};
    assign step_x   = e2 >= $signed({dy_reg[EW-1], dy_reg});
    assign step_y   = e2 <= $signed({dx_reg[EW-1], dx_reg});
    assign err_step = err_reg + (step_x ? dy_reg : '0) + (step_y ? dx_reg : '0);

    always_comb begin
        case (cmd.emit_src)
            gps_pkg::SRC_FIRST:  src_pt = first_reg;
            gps_pkg::SRC_SECOND: src_pt = second_reg;
            gps_pkg::SRC_CORNER: src_pt = pa_reg;
            default:             src_pt = end_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= gps_pkg::DIM_RESET;
            map_height_reg <= gps_pkg::DIM_RESET;
            cc_reg         <= '0;
            raw_reg        <= gps_pkg::RAW_ZERO;
            pending_reg    <= '0;
            second_reg     <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    gps_pkg::REG_WIDTH:  map_width_reg  <= cfg_data;
                    gps_pkg::REG_HEIGHT: map_height_reg <= cfg_data;
                    default:             map_width_reg  <= map_width_reg;
                endcase
            end
            if (path_acc) begin
                if (raw_reg == gps_pkg::RAW_ZERO) begin
                    if (!s_data.path_end) begin
                        cc_reg  <= NW'(1);
                        raw_reg <= gps_pkg::RAW_ONE;
                    end
                end else if (raw_reg == gps_pkg::RAW_ONE) begin
                    if (!s_data.path_end) begin
                        second_reg  <= p_in;
                        pending_reg <= p_in;
                        raw_reg     <= gps_pkg::RAW_TWO;
                    end
                end else if (cross_case) begin
                    if (cross_nz) begin
                        if (room) begin
                            cc_reg <= cc_reg + NW'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    pending_reg <= p_in;
                    raw_reg     <= gps_pkg::RAW_MANY;
                end
            end
            if (cmd.clear_path) begin
                cc_reg      <= '0;
                raw_reg     <= gps_pkg::RAW_ZERO;
                pending_reg <= '0;
                second_reg  <= '0;
                ovf_reg     <= 1'b0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (path_acc) begin
            end_reg <= p_in;
            if (raw_reg == gps_pkg::RAW_ZERO) begin
                first_reg <= p_in;
                last_reg  <= p_in;
            end else if (cross_case && cross_nz && room) begin
                last_reg <= pending_reg;
            end
        end
        if (cmd.store_end) begin
            n_reg <= cc_reg + NW'(1);
            i_reg <= '0;
        end
        if (cmd.load_i) begin
            pa_reg  <= c_rdata;
            j_reg   <= AW'(n_reg - NW'(1));
            far_reg <= i_reg + AW'(1);
        end
        if (cmd.load_j) begin
            pb_reg  <= c_rdata;
            wx_reg  <= pa_reg.x;
            wy_reg  <= pa_reg.y;
            dx_reg  <= $signed({{(EW-CW){1'b0}}, ax});
            dy_reg  <= -$signed({{(EW-CW){1'b0}}, ay});
            err_reg <= $signed({{(EW-CW){1'b0}}, ax}) - $signed({{(EW-CW){1'b0}}, ay});
            sx_reg  <= pa_reg.x < b_pt.x;
            sy_reg  <= pa_reg.y < b_pt.y;
        end
        if (cmd.walk_step) begin
            err_reg <= err_step;
            if (step_x) begin
                wx_reg <= sx_reg ? wx_reg + CW'(1) : wx_reg - CW'(1);
            end
            if (step_y) begin
                wy_reg <= sy_reg ? wy_reg + CW'(1) : wy_reg - CW'(1);
            end
        end
        if (cmd.dec_j) begin
            j_reg <= j_reg - AW'(1);
        end
        if (cmd.take_far_j) begin
            far_reg <= j_reg;
        end
        if (cmd.next_i) begin
            i_reg <= far_reg;
        end
        if (cmd.emit) begin
            m_data_reg <= '{out_x: src_pt.x, out_y: src_pt.y,
                            out_last: cmd.emit_last, overflow: ovf_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.in_op     = s_data.operation;
    assign sts.in_end    = s_data.path_end;
    assign sts.raw       = raw_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.j_more    = {1'b0, j_reg} > ({1'b0, i_reg} + NW'(1));
    assign sts.bounds_ok = ({1'b0, pa_reg.x} < map_width_reg) &&
                           ({1'b0, pa_reg.y} < map_height_reg) &&
                           ({1'b0, pb_reg.x} < map_width_reg) &&
                           ({1'b0, pb_reg.y} < map_height_reg);
    assign sts.blocked   = map_rdata;
    assign sts.at_end    = (wx_reg == pb_reg.x) && (wy_reg == pb_reg.y);
    assign sts.more_i    = ({1'b0, i_reg} + NW'(1)) < n_reg;

endmodule

// File: src/grid_path_shortcut.sv
// Top level of the grid path shortcut: occupancy grid with line-of-sight path pruning.
//
//  Channel   Ports                               Direction  Carries
//  s_        s_valid s_ready s_data              in         grid cell write or path point request
//  m_        m_valid m_ready m_data              out        kept path point with last and overflow
//  cfg_      cfg_valid cfg_ready cfg_index/data  in         map_width (0) or map_height (1) write
//
// A grid write or a non-final point request is taken in ST_IDLE, which it keeps. A final point
// after fewer than three points emits one point per cycle while the output is free. Otherwise the end
// point is stored, a kept corner is fetched (RD_I, LOAD_I), emitted (EMIT_I), advanced (NEXT_I), a
// candidate runs CHECK_J to BOUNDS, WALK_A and WALK_B per cell, and CHECK_J again if none is reachable.
// Reset is synchronous and active low; it clears path state and sets both map sizes to 256.
// The grid is not cleared. s_ready is low during search and emission; a stalled result waits.
`include "grid_path_shortcut_defines.svh"

module grid_path_shortcut (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  gps_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output gps_pkg::out_item_t        m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [gps_pkg::DIM_W-1:0] cfg_data
);

    // Command and status groups between controller and datapath.
    gps_pkg::ctrl_cmd_t  cmd;
    gps_pkg::dp_status_t sts;

    // Map size registers live in the datapath and take a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences requests, the corner search and the emission.
    gps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the grid, the corner store, the line walker and the result register.
    gps_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A result is never loaded over one that is still waiting to be taken.
    `GPS_ASSERT_IMPL(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free)
    // Requests are taken only while nothing is being emitted.
    `GPS_ASSERT_IMPL(a_ready_no_emit, aclk, aresetn, s_ready, !cmd.emit)
    // A final path point always leaves the idle state (emission or corner search), so the input closes next cycle.
    `GPS_ASSERT_NEXT(a_end_closes, aclk, aresetn,
        s_valid && s_ready && s_data.operation == gps_pkg::OP_PATH && s_data.path_end,
        !s_ready)

endmodule

// File: tb/tb_grid_path_shortcut.sv
// Self-checking testbench for grid_path_shortcut, with a scoreboard that predicts the shortcut paths.
module tb_grid_path_shortcut;

    // The scoreboard keeps its own copy of the grid, the map size and the path
    // state. It predicts the emitted points for every accepted request.
    class shortcut_scoreboard;
        bit                 blocked[gps_pkg::MAP_DEPTH];
        int                 map_w;
        int                 map_h;
        gps_pkg::point_t    corners[gps_pkg::MAX_CORNERS];
        int                 n_corners;
        int                 raw_seen;
        gps_pkg::point_t    pending_pt;
        gps_pkg::point_t    second_pt;
        bit                 dropped;
        gps_pkg::out_item_t expected_q[$];
        int                 errors;

        function new();
            map_w = gps_pkg::MAX_SIDE;
            map_h = gps_pkg::MAX_SIDE;
            errors = 0;
            clear_path();
        endfunction

        function void clear_path();
            n_corners = 0;
            raw_seen = 0;
            pending_pt = '0;
            second_pt = '0;
            dropped = 0;
        endfunction

        function void write_reg(logic idx, logic [gps_pkg::DIM_W-1:0] val);
            if (idx == gps_pkg::REG_WIDTH) begin
                map_w = val;
            end else begin
                map_h = val;
            end
        endfunction

        function bit in_map(int x, int y);
            int w;
            int h;
            w = (map_w < gps_pkg::MAX_SIDE) ? map_w : gps_pkg::MAX_SIDE;
            h = (map_h < gps_pkg::MAX_SIDE) ? map_h : gps_pkg::MAX_SIDE;
            return x >= 0 && y >= 0 && x < w && y < h;
        endfunction

        // Bresenham walk from a to b; every cell must be inside the map and free.
        function bit sight_clear(gps_pkg::point_t a, gps_pkg::point_t b);
            int x0, y0, x1, y1, dx, dy, sx, sy, err, e2;
            x0 = a.x; y0 = a.y; x1 = b.x; y1 = b.y;
            if (!in_map(x0, y0) || !in_map(x1, y1)) begin
                return 0;
            end
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = dx + dy;
            forever begin
                if (blocked[y0 * gps_pkg::MAX_SIDE + x0]) begin
                    return 0;
                end
                if (x0 == x1 && y0 == y1) begin
                    break;
                end
                e2 = 2 * err;
                if (e2 >= dy) begin
                    err += dy;
                    x0 += sx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    y0 += sy;
                end
            end
            return 1;
        endfunction

        function void expect_point(gps_pkg::point_t p, bit last);
            gps_pkg::out_item_t o;
            o.out_x = p.x;
            o.out_y = p.y;
            o.out_last = last;
            o.overflow = dropped;
            expected_q = {expected_q, o};
        endfunction

        function void note_request(gps_pkg::in_item_t r);
            gps_pkg::point_t p;
            gps_pkg::point_t a;
            int              vx1, vy1, vx2, vy2, i, j, far;
            if (r.operation == gps_pkg::OP_GRID) begin
                blocked[{r.cell_y, r.cell_x}] = (r.occupancy == gps_pkg::BLOCKED_CODE);
                return;
            end
            p.x = r.cell_x;
            p.y = r.cell_y;
            if (raw_seen == 0) begin
                if (r.path_end) begin
                    expect_point(p, 1);
                    clear_path();
                end else begin
                    corners[0] = p;
                    n_corners = 1;
                    raw_seen = 1;
                end
                return;
            end
            if (raw_seen == 1) begin
                if (r.path_end) begin
                    expect_point(corners[0], 0);
                    expect_point(p, 1);
                    clear_path();
                end else begin
                    second_pt = p;
                    pending_pt = p;
                    raw_seen = 2;
                end
                return;
            end
            if (raw_seen == 2 && r.path_end) begin
                expect_point(corners[0], 0);
                expect_point(second_pt, 0);
                expect_point(p, 1);
                clear_path();
                return;
            end
            // Keep the pending point only if it turns a corner.
            a = corners[(n_corners - 1) % gps_pkg::MAX_CORNERS];
            vx1 = int'(pending_pt.x) - int'(a.x);
            vy1 = int'(pending_pt.y) - int'(a.y);
            vx2 = int'(p.x) - int'(pending_pt.x);
            vy2 = int'(p.y) - int'(pending_pt.y);
            if (vx1 * vy2 - vy1 * vx2 != 0) begin
                if (n_corners < gps_pkg::MAX_CORNERS - 1) begin
                    corners[n_corners] = pending_pt;
                    n_corners++;
                end else begin
                    dropped = 1;
                end
            end
            pending_pt = p;
            raw_seen = 3;
            if (!r.path_end) begin
                return;
            end
            if (n_corners > gps_pkg::MAX_CORNERS - 1) begin
                n_corners = gps_pkg::MAX_CORNERS - 1;
            end
            corners[n_corners] = p;
            n_corners++;
            i = 0;
            while (i < n_corners - 1) begin
                far = i + 1;
                for (j = n_corners - 1; j > i + 1; j--) begin
                    if (sight_clear(corners[i], corners[j])) begin
                        far = j;
                        break;
                    end
                end
                expect_point(corners[i], 0);
                i = far;
            end
            expect_point(corners[n_corners - 1], 1);
            clear_path();
        endfunction

        function void check_result(gps_pkg::out_item_t got);
            gps_pkg::out_item_t exp_pt;
            if (expected_q.size() == 0) begin
                $display("%0t: expected no point, got x=%0d y=%0d last=%0b ovf=%0b", $time,
                         got.out_x, got.out_y, got.out_last, got.overflow);
                errors++;
                return;
            end
            exp_pt = expected_q.pop_front();
            if (got.out_x !== exp_pt.out_x) begin
                $display("%0t: out_x expected %0d got %0d", $time, exp_pt.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== exp_pt.out_y) begin
                $display("%0t: out_y expected %0d got %0d", $time, exp_pt.out_y, got.out_y);
                errors++;
            end
            if (got.out_last !== exp_pt.out_last) begin
                $display("%0t: out_last expected %0b got %0b", $time,
                         exp_pt.out_last, got.out_last);
                errors++;
            end
            if (got.overflow !== exp_pt.overflow) begin
                $display("%0t: overflow expected %0b got %0b", $time,
                         exp_pt.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    // Every walked line stays inside this square of the grid, which is fully written up front,
    // so no line walk ever touches a cell that was never written.
    localparam int REGION = 12;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int STALL_CYCLES = 400;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    gps_pkg::in_item_t            s_data;
    logic                         m_valid;
    logic                         m_ready;
    gps_pkg::out_item_t           m_data;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic                         cfg_index;
    logic [gps_pkg::DIM_W-1:0]    cfg_data;

    shortcut_scoreboard  sb;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    bit                  stall_req;
    int                  quiet_cycles;

    grid_path_shortcut uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Monitors: every accepted request feeds the predictor, every accepted result
    // is checked against the oldest prediction. Inputs move on the falling edge,
    // so sampling here is free of races.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
        end
    end

    // Watchdog: a long run of cycles in which no channel moves anything means the
    // block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side. A pending stall request holds m_ready low for a long stretch,
    // so the block fills up and has to push back on the request side.
    initial begin
        m_ready <= 0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                m_ready <= 0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_req = 0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Called at a falling edge. Valid stays high after acceptance so that
    // back-to-back requests never lower and raise it in the same step. Each idle
    // cycle is drawn on its own, so the sender idles in the given share of cycles.
    task automatic send_request(input gps_pkg::in_item_t req);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_cell(input logic [7:0] x, input logic [7:0] y,
                              input logic signed [7:0] occ);
        gps_pkg::in_item_t req;
        req = '0;
        req.operation = gps_pkg::OP_GRID;
        req.cell_x = x;
        req.cell_y = y;
        req.occupancy = occ;
        send_request(req);
    endtask

    task automatic send_point(input logic [7:0] x, input logic [7:0] y, input bit last);
        gps_pkg::in_item_t req;
        req.operation = gps_pkg::OP_PATH;
        req.cell_x = x;
        req.cell_y = y;
        req.occupancy = 8'($urandom);
        req.path_end = last;
        send_request(req);
    endtask

    task automatic random_cell_write();
        logic [7:0]        x;
        logic [7:0]        y;
        logic signed [7:0] occ;
        if ($urandom_range(0, 1)) begin
            x = 8'($urandom_range(0, REGION - 1));
            y = 8'($urandom_range(0, REGION - 1));
        end else begin
            x = 8'($urandom);
            y = 8'($urandom);
        end
        occ = ($urandom_range(0, 3) == 0) ? gps_pkg::BLOCKED_CODE : 8'($urandom);
        write_cell(x, y, occ);
    endtask

    // Mostly a coordinate inside the written square; when the map is narrower than
    // the square, sometimes one beyond the map edge, which the block must treat
    // as out of bounds without walking it.
    function automatic logic [7:0] pick_coord(input int lim);
        if (lim < REGION && $urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(lim, 255));
        end
        return 8'($urandom_range(0, REGION - 1));
    endfunction

    // One path of the given length; some steps repeat the last direction so
    // collinear runs occur, and grid writes are mixed in between points.
    task automatic random_path(input int len);
        int         xlim, ylim, sx, sy, nx, ny, k;
        logic [7:0] px, py;
        xlim = (sb.map_w < gps_pkg::MAX_SIDE) ? sb.map_w : gps_pkg::MAX_SIDE;
        ylim = (sb.map_h < gps_pkg::MAX_SIDE) ? sb.map_h : gps_pkg::MAX_SIDE;
        px = pick_coord(xlim);
        py = pick_coord(ylim);
        sx = 1;
        sy = 0;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                random_cell_write();
            end
            if (k > 0) begin
                nx = int'(px) + sx;
                ny = int'(py) + sy;
                if ($urandom_range(0, 2) == 0 && nx >= 0 && ny >= 0
                        && nx < REGION && ny < REGION) begin
                    px = 8'(nx);
                    py = 8'(ny);
                end else begin
                    nx = pick_coord(xlim);
                    ny = pick_coord(ylim);
                    sx = nx - int'(px);
                    sy = ny - int'(py);
                    px = 8'(nx);
                    py = 8'(ny);
                end
            end
            send_point(px, py, k == len - 1);
        end
    endtask

    // A zigzag inside the square where every interior point turns, so the corner
    // store runs out of slots when the path is long enough.
    task automatic zigzag_path(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            send_point(8'(k % REGION), 8'(k % 2 + 2 * (k / REGION)), k == len - 1);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [gps_pkg::DIM_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // Lets the block drain before the map size changes. Grid writes leave nothing
    // to wait for, so a few cycles more cover the one in flight.
    task automatic drain();
        s_valid <= 0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    int widths[7]  = '{511, 1, 8, 256, 0, 16, 256};
    int heights[7] = '{256, 1, 200, 5, 16, 0, 256};

    initial begin
        int ph, pts, len, x, y;
        sb = new();
        aresetn <= 0;
        s_valid <= 0;
        s_data <= '0;
        cfg_valid <= 0;
        cfg_index <= gps_pkg::REG_WIDTH;
        cfg_data <= '0;
        stall_req = 0;
        tx_idle_pct = 35;
        rx_idle_pct = 66;
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Fill the working square so every line walked later reads written cells.
        for (y = 0; y < REGION; y++) begin
            for (x = 0; x < REGION; x++) begin
                write_cell(8'(x), 8'(y),
                           ($urandom_range(0, 99) < 15) ? gps_pkg::BLOCKED_CODE
                                                        : 8'($urandom));
            end
        end

        // Directed: occupancy extremes, far cells, the short paths that bypass the
        // search, a collinear run and a shortcut blocked by a wall.
        write_cell(8'd255, 8'd255, 8'sh80);
        write_cell(8'd254, 8'd0, 8'sh7f);
        write_cell(8'd0, 8'd0, 8'sd99);
        send_point(8'd15, 8'd15, 1);
        send_point(8'd0, 8'd0, 0);
        send_point(8'd15, 8'd0, 1);
        send_point(8'd1, 8'd2, 0);
        send_point(8'd2, 8'd2, 0);
        send_point(8'd3, 8'd9, 1);
        for (x = 0; x < 5; x++) begin
            write_cell(8'(x + 1), 8'(x + 1), 8'sd0);
        end
        for (x = 0; x < 5; x++) begin
            send_point(8'(x), 8'(x), x == 4);
        end
        write_cell(8'd6, 8'd4, gps_pkg::BLOCKED_CODE);
        send_point(8'd4, 8'd4, 0);
        send_point(8'd5, 8'd2, 0);
        send_point(8'd7, 8'd3, 0);
        send_point(8'd8, 8'd4, 1);
        drain();

        for (ph = 0; ph < 7; ph++) begin
            if (ph < 2) begin
                tx_idle_pct = 35;
                rx_idle_pct = 66;
            end else if (ph < 4) begin
                tx_idle_pct = 66;
                rx_idle_pct = 35;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_reg(gps_pkg::REG_WIDTH, gps_pkg::DIM_W'(widths[ph]));
            write_reg(gps_pkg::REG_HEIGHT, gps_pkg::DIM_W'(heights[ph]));
            if (ph == 4) begin
                stall_req = 1;
            end
            pts = 0;
            if (ph == 0) begin
                // Enough turning points to run out of corner slots.
                zigzag_path(70);
            end
            while (pts < 20) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 14);
                random_path(len);
                pts += len;
            end
            drain();
        end

        repeat (50) @(negedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: grid_path_shortcut.f
+incdir+src
src/gps_pkg.sv
src/gps_ram.sv
src/gps_ctrl.sv
src/gps_dp.sv
src/grid_path_shortcut.sv
tb/tb_grid_path_shortcut.sv
